FILE: src/scc_pkg.sv
// Shared types, codes and constants of the sequence context convolution.
package scc_pkg;

    localparam int DEF_MAX_CONTEXT  = 4;
    localparam int DEF_MAX_HIDDEN   = 64;
    localparam int DEF_MAX_FILTERS  = 16;
    localparam int DEF_MAX_SEQUENCE = 4096;

    localparam int DATA_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int POS_W      = 12;
    localparam int FNUM_W     = 4;
    localparam int WIDX_W     = 12;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_START   = 2'd0,
        REG_LENGTH  = 2'd1,
        REG_HIDDEN  = 2'd2,
        REG_FILTERS = 2'd3
    } reg_index_t;

    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    localparam logic [2:0] RST_START   = 3'b111;
    localparam logic [2:0] RST_LENGTH  = 3'd3;
    localparam logic [6:0] RST_HIDDEN  = 7'd64;
    localparam logic [4:0] RST_FILTERS = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_FILT,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic valid;
        logic use_row;
        logic end_flag;
    } issue_t;

endpackage

FILE: src/sequence_context_convolution.sv
// Top level: context convolution over streamed feature rows.
//
// Input stream s_*: weight loads (tuser[0]=0) write the weight store at
// weight_index; feature elements (tuser[0]=1) fill the current row.
// tlast marks the last element of a row, tuser[1] the end of a sequence.
// Result stream m_*: one transfer per filter of each finished row, in row
// order then filter order; tlast marks the final result of one input.
// Registers must be written through cfg_wen/cfg_addr/cfg_wdata only while
// idle; the block itself does not enforce this. Loads and row elements
// are accepted only while idle. For each row that a row end releases,
// one shared multiplier walks len*hid products per filter, fed by one
// registered read port on each memory, after an accumulator clear and
// before a drain into the output register.
// A result waits in the output register while the receiver stalls;
// the next filter starts only once that register is free. After the last
// result of an item is registered, the block passes through the row and
// done states back to idle before it takes a new item.
// Reset (aresetn low, synchronous) clears row and sequence counters and
// restores register defaults; weights and row data are kept.
module sequence_context_convolution #(
    parameter int MAX_CONTEXT  = scc_pkg::DEF_MAX_CONTEXT,
    parameter int MAX_HIDDEN   = scc_pkg::DEF_MAX_HIDDEN,
    parameter int MAX_FILTERS  = scc_pkg::DEF_MAX_FILTERS,
    parameter int MAX_SEQUENCE = scc_pkg::DEF_MAX_SEQUENCE
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [scc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [scc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // weight_index, value, pad
    input  logic [1:0]                          s_tuser,  // kind, end_of_sequence
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,  // row_position, filter_number,
                                                          // output_value
    output logic                                m_tlast
);
    localparam int WSIZE   = MAX_CONTEXT * MAX_HIDDEN * MAX_FILTERS;
    localparam int WAW     = WSIZE > 1 ? $clog2(WSIZE) : 1;
    localparam int SW      = MAX_CONTEXT > 1 ? $clog2(MAX_CONTEXT) : 1;
    localparam int EW      = MAX_HIDDEN > 1 ? $clog2(MAX_HIDDEN) : 1;
    localparam int HW      = $clog2(MAX_HIDDEN + 1);
    localparam int CW      = $clog2(MAX_CONTEXT + 1);
    localparam int FW      = $clog2(MAX_FILTERS + 1);
    localparam int FIW     = MAX_FILTERS > 1 ? $clog2(MAX_FILTERS) : 1;
    localparam int ROW_CAP = MAX_SEQUENCE + MAX_CONTEXT;
    localparam int RW      = $clog2(ROW_CAP + 1);
    localparam int POS_MAX = (MAX_SEQUENCE - 1) < 4095 ? (MAX_SEQUENCE - 1) : 4095;

    logic [2:0]  cfg_start_reg;
    logic [2:0]  cfg_length_reg;
    logic [6:0]  cfg_hidden_reg;
    logic [4:0]  cfg_filters_reg;

    scc_pkg::state_t state_reg, state_next;

    logic [HW-1:0]  ec_reg;
    logic [RW-1:0]  rows_reg;
    logic [RW-1:0]  next_reg;
    logic [SW-1:0]  ring_reg;
    logic           eos_reg;
    logic           lastrow_reg;
    logic [FIW-1:0] f_reg;
    logic [CW-1:0]  k_reg;
    logic [EW-1:0]  e_reg;
    logic [WAW-1:0] widx_reg;
    logic           m_tvalid_reg;
    logic           m_tlast_reg;
    logic [55:0]    m_tdata_reg;

    logic                              in_kind;
    logic [scc_pkg::WIDX_W-1:0]        in_widx;
    logic signed [scc_pkg::DATA_W-1:0] in_value;
    logic                              in_eos;
    logic                              in_eor;
    logic                              accept;
    logic                              feat_acc;

    logic [3:0]     neg_start;
    logic signed [3:0] s4;
    logic [3:0]     neg4;
    logic [CW-1:0]  len_eff;
    logic [HW-1:0]  hid_eff;
    logic [FW-1:0]  flt_eff;
    logic [4:0]     len_raw;
    logic [10:0]    hid_raw;
    logic [6:0]     flt_raw;
    logic signed [5:0] dsig;
    logic [3:0]     d_eff;

    logic [RW-1:0]  cur;
    logic [RW:0]    n0, n1, cur_e;
    logic           cond0, cond1;
    logic [RW:0]    nk;
    logic [RW+2:0]  dist_u;
    logic           row_ok;
    logic [SW:0]    dist_s, ring_e, slot_w;
    logic [SW-1:0]  rd_slot;
    logic           e_last, k_last, f_last;

    scc_pkg::issue_t issue;
    scc_pkg::issue_t mem_tag;
    logic signed [scc_pkg::DATA_W-1:0] hist_val, weight_val;
    logic            mac_clr;
    logic            mac_done;
    logic signed [scc_pkg::ACC_W-1:0] mac_sum;
    logic            filt_go;
    logic [RW-1:0]   pos_sat;

    assign in_widx  = s_tdata[11:0];
    assign in_value = s_tdata[27:12];
    assign in_kind  = s_tuser[0];
    assign in_eos   = s_tuser[1];
    assign in_eor   = s_tlast || in_eos;
    assign accept   = s_tvalid && s_tready;
    assign feat_acc = accept && (in_kind == scc_pkg::KIND_FEATURE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_start_reg   <= scc_pkg::RST_START;
            cfg_length_reg  <= scc_pkg::RST_LENGTH;
            cfg_hidden_reg  <= scc_pkg::RST_HIDDEN;
            cfg_filters_reg <= scc_pkg::RST_FILTERS;
        end else if (cfg_wen) begin
            case (cfg_addr)
                scc_pkg::REG_START:   cfg_start_reg   <= cfg_wdata[2:0];
                scc_pkg::REG_LENGTH:  cfg_length_reg  <= cfg_wdata[2:0];
                scc_pkg::REG_HIDDEN:  cfg_hidden_reg  <= cfg_wdata;
                scc_pkg::REG_FILTERS: cfg_filters_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s4   = $signed({cfg_start_reg[2], cfg_start_reg});
        neg4 = 4'(-s4);
        if (s4 > 4'sd0) begin
            neg_start = '0;
        end else if (neg4 > 4'(MAX_CONTEXT - 1)) begin
            neg_start = 4'(MAX_CONTEXT - 1);
        end else begin
            neg_start = neg4;
        end
        len_raw = 5'(cfg_length_reg);
        if (len_raw == '0) len_eff = CW'(1);
        else if (len_raw > 5'(MAX_CONTEXT)) len_eff = CW'(MAX_CONTEXT);
        else len_eff = CW'(len_raw);
        hid_raw = 11'(cfg_hidden_reg);
        if (hid_raw == '0) hid_eff = HW'(1);
        else if (hid_raw > 11'(MAX_HIDDEN)) hid_eff = HW'(MAX_HIDDEN);
        else hid_eff = HW'(hid_raw);
        flt_raw = 7'(cfg_filters_reg);
        if (flt_raw == '0) flt_eff = FW'(1);
        else if (flt_raw > 7'(MAX_FILTERS)) flt_eff = FW'(MAX_FILTERS);
        else flt_eff = FW'(flt_raw);
        dsig  = $signed(6'(len_eff)) - 6'sd1 - $signed(6'(neg_start));
        d_eff = dsig < 6'sd0 ? 4'd0 : 4'(dsig);
    end

    always_comb begin
        cur   = rows_reg - RW'(1);
        cur_e = {1'b0, cur};
        n0    = {1'b0, next_reg};
        n1    = n0 + (RW+1)'(1);
        cond0 = (n0 + (RW+1)'(d_eff) <= cur_e) || (eos_reg && n0 <= cur_e);
        cond1 = (n1 + (RW+1)'(d_eff) <= cur_e) || (eos_reg && n1 <= cur_e);
        nk     = n0 + (RW+1)'(k_reg);
        row_ok = nk >= (RW+1)'(neg_start);
        dist_u = (RW+3)'(cur) + (RW+3)'(neg_start) - (RW+3)'(nk);
        dist_s = (SW+1)'(dist_u);
        ring_e = (SW+1)'(ring_reg);
        slot_w = ring_e >= dist_s ? ring_e - dist_s
                                  : ring_e + (SW+1)'(MAX_CONTEXT) - dist_s;
        rd_slot = SW'(slot_w);
        e_last = HW'(e_reg) == hid_eff - HW'(1);
        k_last = k_reg == len_eff - CW'(1);
        f_last = FW'(f_reg) == flt_eff - FW'(1);
        pos_sat = next_reg > RW'(POS_MAX) ? RW'(POS_MAX) : next_reg;
    end

    assign filt_go = (state_reg == scc_pkg::ST_FILT) && !m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scc_pkg::ST_IDLE:  if (feat_acc && in_eor) state_next = scc_pkg::ST_ROW;
            scc_pkg::ST_ROW:   state_next = cond0 ? scc_pkg::ST_FILT : scc_pkg::ST_DONE;
            scc_pkg::ST_FILT:  if (filt_go) state_next = scc_pkg::ST_ISSUE;
            scc_pkg::ST_ISSUE: if (e_last && k_last) state_next = scc_pkg::ST_DRAIN;
            scc_pkg::ST_DRAIN: if (mac_done) begin
                state_next = f_last ? scc_pkg::ST_ROW : scc_pkg::ST_FILT;
            end
            scc_pkg::ST_DONE:  state_next = scc_pkg::ST_IDLE;
            default:           state_next = scc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = state_reg == scc_pkg::ST_IDLE;
        mac_clr        = filt_go;
        issue.valid    = state_reg == scc_pkg::ST_ISSUE;
        issue.use_row  = (state_reg == scc_pkg::ST_ISSUE) && row_ok && !dist_u[RW+2]
                         && dist_u <= (RW+3)'(MAX_CONTEXT - 1);
        issue.end_flag = e_last && k_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= scc_pkg::ST_IDLE;
            ec_reg       <= '0;
            rows_reg     <= '0;
            next_reg     <= '0;
            ring_reg     <= '0;
            eos_reg      <= 1'b0;
            lastrow_reg  <= 1'b0;
            f_reg        <= '0;
            k_reg        <= '0;
            e_reg        <= '0;
            widx_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                scc_pkg::ST_IDLE: begin
                    if (feat_acc) begin
                        if (in_eor) begin
                            ec_reg  <= '0;
                            eos_reg <= in_eos;
                            if (rows_reg >= RW'(ROW_CAP)) next_reg <= next_reg - RW'(1);
                            else rows_reg <= rows_reg + RW'(1);
                        end else if (ec_reg != HW'(MAX_HIDDEN)) begin
                            ec_reg <= ec_reg + HW'(1);
                        end
                    end
                end
                scc_pkg::ST_ROW: begin
                    lastrow_reg <= !cond1;
                    f_reg       <= '0;
                end
                scc_pkg::ST_FILT: begin
                    k_reg    <= '0;
                    e_reg    <= '0;
                    widx_reg <= WAW'(f_reg);
                end
                scc_pkg::ST_ISSUE: begin
                    widx_reg <= widx_reg + WAW'(flt_eff);
                    if (e_last) begin
                        e_reg <= '0;
                        k_reg <= k_reg + CW'(1);
                    end else begin
                        e_reg <= e_reg + EW'(1);
                    end
                end
                scc_pkg::ST_DRAIN: begin
                    if (mac_done) begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= lastrow_reg && f_last;
                        if (f_last) next_reg <= next_reg + RW'(1);
                        else f_reg <= f_reg + FIW'(1);
                    end
                end
                scc_pkg::ST_DONE: begin
                    ring_reg <= (ring_reg == SW'(MAX_CONTEXT - 1)) ? '0 : ring_reg + SW'(1);
                    if (eos_reg) begin
                        rows_reg <= '0;
                        next_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == scc_pkg::ST_DRAIN && mac_done) begin
            m_tdata_reg <= {mac_sum, scc_pkg::FNUM_W'(f_reg), scc_pkg::POS_W'(pos_sat)};
        end
    end

    scc_mem #(
        .MAX_CONTEXT (MAX_CONTEXT),
        .MAX_HIDDEN  (MAX_HIDDEN),
        .MAX_FILTERS (MAX_FILTERS)
    ) u_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .w_wen      (accept && (in_kind == scc_pkg::KIND_WEIGHT)
                     && (32'(in_widx) < 32'(WSIZE))),
        .w_waddr    (WAW'(in_widx)),
        .w_wdata    (in_value),
        .h_wen      (feat_acc && (ec_reg < hid_eff)),
        .h_fill_wen (feat_acc && ((ec_reg < hid_eff) || (ec_reg == '0))),
        .h_wslot    (ring_reg),
        .h_waddr    (EW'(ec_reg)),
        .h_fill_val ((ec_reg < hid_eff) ? ec_reg + HW'(1) : '0),
        .h_wdata    (in_value),
        .rd_tag     (issue),
        .rd_slot    (rd_slot),
        .rd_e       (e_reg),
        .rd_waddr   (widx_reg),
        .out_tag    (mem_tag),
        .hist_val   (hist_val),
        .weight_val (weight_val)
    );

    scc_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr        (mac_clr),
        .in_tag     (mem_tag),
        .hist_val   (hist_val),
        .weight_val (weight_val),
        .done       (mac_done),
        .sum        (mac_sum)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> !m_tvalid_reg)
        else $error("result finished while output register still full");
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == scc_pkg::ST_DONE |=> state_reg == scc_pkg::ST_IDLE)
        else $error("row end did not return to idle");
    a_next_le_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == scc_pkg::ST_IDLE |-> next_reg <= rows_reg)
        else $error("output row ahead of received rows");
    a_done_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == scc_pkg::ST_DRAIN)
        else $error("accumulator finished outside drain");
`endif

endmodule

FILE: src/scc_mem.sv
// Weight store, row history memory and per-slot fill counts.
module scc_mem #(
    parameter int MAX_CONTEXT = scc_pkg::DEF_MAX_CONTEXT,
    parameter int MAX_HIDDEN  = scc_pkg::DEF_MAX_HIDDEN,
    parameter int MAX_FILTERS = scc_pkg::DEF_MAX_FILTERS,
    localparam int WSIZE = MAX_CONTEXT * MAX_HIDDEN * MAX_FILTERS,
    localparam int WAW   = WSIZE > 1 ? $clog2(WSIZE) : 1,
    localparam int SW    = MAX_CONTEXT > 1 ? $clog2(MAX_CONTEXT) : 1,
    localparam int EW    = MAX_HIDDEN > 1 ? $clog2(MAX_HIDDEN) : 1,
    localparam int HW    = $clog2(MAX_HIDDEN + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           w_wen,
    input  logic [WAW-1:0]                 w_waddr,
    input  logic signed [scc_pkg::DATA_W-1:0] w_wdata,
    input  logic                           h_wen,
    input  logic                           h_fill_wen,
    input  logic [SW-1:0]                  h_wslot,
    input  logic [EW-1:0]                  h_waddr,
    input  logic [HW-1:0]                  h_fill_val,
    input  logic signed [scc_pkg::DATA_W-1:0] h_wdata,
    input  scc_pkg::issue_t                rd_tag,
    input  logic [SW-1:0]                  rd_slot,
    input  logic [EW-1:0]                  rd_e,
    input  logic [WAW-1:0]                 rd_waddr,
    output scc_pkg::issue_t                out_tag,
    output logic signed [scc_pkg::DATA_W-1:0] hist_val,
    output logic signed [scc_pkg::DATA_W-1:0] weight_val
);
    logic signed [scc_pkg::DATA_W-1:0] wmem [WSIZE];
    logic signed [scc_pkg::DATA_W-1:0] hmem [MAX_CONTEXT][MAX_HIDDEN];
    logic [HW-1:0]                     fill_reg [MAX_CONTEXT];
    logic signed [scc_pkg::DATA_W-1:0] h_rd_reg;
    logic signed [scc_pkg::DATA_W-1:0] w_rd_reg;
    scc_pkg::issue_t                   tag_reg;
    scc_pkg::issue_t                   tag_next;

    always_ff @(posedge aclk) begin
        if (w_wen) begin
            wmem[w_waddr] <= w_wdata;
        end
        w_rd_reg <= wmem[rd_waddr];
    end

    always_ff @(posedge aclk) begin
        if (h_wen) begin
            hmem[h_wslot][h_waddr] <= h_wdata;
        end
        h_rd_reg <= hmem[rd_slot][rd_e];
    end

    always_comb begin
        tag_next = rd_tag;
        tag_next.use_row = rd_tag.use_row && (HW'(rd_e) < fill_reg[rd_slot]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
            for (int i = 0; i < MAX_CONTEXT; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            tag_reg <= tag_next;
            if (h_fill_wen) begin
                fill_reg[h_wslot] <= h_fill_val;
            end
        end
    end

    assign out_tag    = tag_reg;
    assign hist_val   = tag_reg.use_row ? h_rd_reg : '0;
    assign weight_val = w_rd_reg;

endmodule

FILE: src/scc_mac.sv
// Registered multiplier and 40-bit accumulator.
module scc_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              clr,
    input  scc_pkg::issue_t                   in_tag,
    input  logic signed [scc_pkg::DATA_W-1:0] hist_val,
    input  logic signed [scc_pkg::DATA_W-1:0] weight_val,
    output logic                              done,
    output logic signed [scc_pkg::ACC_W-1:0]  sum
);
    logic signed [scc_pkg::PROD_W-1:0] prod_reg;
    logic signed [scc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [scc_pkg::ACC_W-1:0]  acc_next;
    logic                              p_valid_reg;
    logic                              p_end_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= hist_val * weight_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            p_end_reg   <= 1'b0;
        end else begin
            p_valid_reg <= in_tag.valid;
            p_end_reg   <= in_tag.valid && in_tag.end_flag;
        end
    end

    assign acc_next = acc_reg + scc_pkg::ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (clr) begin
            acc_reg <= '0;
        end else if (p_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign done = p_valid_reg && p_end_reg;
    assign sum  = acc_next;

endmodule
